// File: rtl/wpsp_pkg.sv
`default_nettype none
package wpsp_pkg;

	// chunk tags as they arrive, first byte in the low lane
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [7:0]  PCM_CENTER  = 8'd128;
	localparam logic [31:0] FMT_MIN_LEN = 32'd16;

	// parse phases
	localparam logic [2:0] PH_RIFF = 3'd0;
	localparam logic [2:0] PH_HDR  = 3'd1;
	localparam logic [2:0] PH_FMT  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_SKIP = 3'd4;
	localparam logic [2:0] PH_PAD  = 3'd5;
	localparam logic [2:0] PH_WAIT = 3'd6;

	// seen flag bits
	localparam int SEEN_FMT_BIT  = 0;
	localparam int SEEN_DATA_BIT = 1;

	// status codes
	localparam logic [3:0] ST_SAMPLE      = 4'd0;
	localparam logic [3:0] ST_DONE        = 4'd1;
	localparam logic [3:0] ST_BAD_HEADER  = 4'd2;
	localparam logic [3:0] ST_OVERRUN     = 4'd3;
	localparam logic [3:0] ST_SHORT_FMT   = 4'd4;
	localparam logic [3:0] ST_MISSING     = 4'd5;
	localparam logic [3:0] ST_NOT_PCM     = 4'd6;
	localparam logic [3:0] ST_BAD_CHANS   = 4'd7;
	localparam logic [3:0] ST_BAD_BITS    = 4'd8;
	localparam logic [3:0] ST_ODD_DATA    = 4'd9;
	localparam logic [3:0] ST_DATA_NO_FMT = 4'd10;

	localparam logic [15:0] FORMAT_PCM = 16'd1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] sample_value;
		logic               sample_valid;
		logic               channel_index;
		logic [3:0]         status;
		logic [31:0]        sample_rate;
		logic [1:0]         channel_count;
	} out_word_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] byte_in_field;
		logic [31:0] chunk_length;
		logic [31:0] chunk_tag;
		logic [15:0] format_code;
		logic [15:0] channels_held;
		logic [31:0] rate_held;
		logic [15:0] bits_held;
		logic [1:0]  seen_flags;
		logic [7:0]  low_byte_hold;
		logic        channel_toggle;
	} parse_state_t;

	localparam parse_state_t STATE_INIT = '{phase: PH_RIFF, default: '0};

endpackage
`default_nettype wire

// File: rtl/wpsp_step.sv
`default_nettype none
module wpsp_step (
	input  wire wpsp_pkg::parse_state_t cur,
	input  wire wpsp_pkg::in_word_t     word_in,
	output wpsp_pkg::parse_state_t      nxt,
	output wpsp_pkg::out_word_t         res,
	output logic                        res_valid
);
	import wpsp_pkg::*;

	logic [7:0]  b;
	logic [31:0] off;
	logic [31:0] off_inc;
	logic [7:0]  want;
	logic [3:0]  status;
	logic        have;
	logic [15:0] sval;
	logic        ch;

	assign b       = word_in.byte_value;
	assign off     = cur.byte_in_field;
	assign off_inc = off + 32'd1;

	always_comb begin
		nxt    = cur;
		status = ST_SAMPLE;
		have   = 1'b0;
		sval   = '0;
		ch     = 1'b0;
		want   = b;
		res    = '0;

		case (cur.phase)
			PH_RIFF: begin
				if (off < 32'd4) begin
					want = TAG_RIFF[{off[1:0], 3'b000} +: 8];
				end else if (off >= 32'd8 && off < 32'd12) begin
					want = TAG_WAVE[{off[1:0], 3'b000} +: 8];
				end
				if (b != want || off >= 32'd12) begin
					status = ST_BAD_HEADER;
				end else begin
					nxt.byte_in_field = off_inc;
					if (off == 32'd11) begin
						nxt.phase         = PH_HDR;
						nxt.byte_in_field = '0;
						nxt.chunk_tag     = '0;
						nxt.chunk_length  = '0;
					end
				end
			end
			PH_HDR: begin
				if (off < 32'd4) begin
					nxt.chunk_tag[{off[1:0], 3'b000} +: 8] = b;
				end else begin
					nxt.chunk_length[{off[1:0], 3'b000} +: 8] = b;
				end
				nxt.byte_in_field = off_inc;
				if (off >= 32'd7) begin
					nxt.byte_in_field = '0;
					// header complete: decide what the body is
					if (nxt.chunk_tag == TAG_FMT) begin
						if (nxt.chunk_length < FMT_MIN_LEN) begin
							status = ST_SHORT_FMT;
						end else if (cur.seen_flags[SEEN_DATA_BIT]) begin
							nxt.phase = PH_SKIP;
						end else begin
							nxt.format_code                = '0;
							nxt.channels_held              = '0;
							nxt.rate_held                  = '0;
							nxt.bits_held                  = '0;
							nxt.seen_flags[SEEN_FMT_BIT]   = 1'b1;
							nxt.phase                      = PH_FMT;
						end
					end else if (nxt.chunk_tag == TAG_DATA && !cur.seen_flags[SEEN_DATA_BIT]) begin
						if (!cur.seen_flags[SEEN_FMT_BIT]) begin
							status = ST_DATA_NO_FMT;
						end else if (cur.format_code != FORMAT_PCM) begin
							status = ST_NOT_PCM;
						end else if (cur.channels_held != 16'd1 && cur.channels_held != 16'd2) begin
							status = ST_BAD_CHANS;
						end else if (cur.bits_held != 16'd8 && cur.bits_held != 16'd16) begin
							status = ST_BAD_BITS;
						end else if (cur.bits_held == 16'd16 && nxt.chunk_length[0]) begin
							status = ST_ODD_DATA;
						end else begin
							nxt.seen_flags[SEEN_DATA_BIT] = 1'b1;
							nxt.channel_toggle            = 1'b0;
							nxt.phase                     = PH_DATA;
						end
					end else begin
						nxt.phase = PH_SKIP;
					end
					if (status == ST_SAMPLE && nxt.chunk_length == 32'd0) begin
						nxt.phase         = PH_HDR;
						nxt.byte_in_field = '0;
						nxt.chunk_tag     = '0;
						nxt.chunk_length  = '0;
					end
				end
			end
			PH_FMT, PH_DATA, PH_SKIP: begin
				if (cur.phase == PH_FMT) begin
					if (off < 32'd2) begin
						nxt.format_code[{off[0], 3'b000} +: 8] = b;
					end else if (off < 32'd4) begin
						nxt.channels_held[{off[0], 3'b000} +: 8] = b;
					end else if (off < 32'd8) begin
						nxt.rate_held[{off[1:0], 3'b000} +: 8] = b;
					end else if (off == 32'd14 || off == 32'd15) begin
						nxt.bits_held[{off[0], 3'b000} +: 8] = b;
					end
				end else if (cur.phase == PH_DATA) begin
					if (cur.bits_held == 16'd8) begin
						sval = {b ^ PCM_CENTER, 8'h00};
						have = 1'b1;
					end else if (!off[0]) begin
						nxt.low_byte_hold = b;
					end else begin
						sval = {b, cur.low_byte_hold};
						have = 1'b1;
					end
					if (have) begin
						ch = cur.channel_toggle;
						if (cur.channels_held == 16'd2) begin
							nxt.channel_toggle = ~cur.channel_toggle;
						end
					end
				end
				nxt.byte_in_field = off_inc;
				if (off_inc == cur.chunk_length) begin
					if (cur.chunk_length[0]) begin
						nxt.phase         = PH_PAD;
						nxt.byte_in_field = '0;
					end else begin
						nxt.phase         = PH_HDR;
						nxt.byte_in_field = '0;
						nxt.chunk_tag     = '0;
						nxt.chunk_length  = '0;
					end
				end
			end
			PH_PAD: begin
				nxt.phase         = PH_HDR;
				nxt.byte_in_field = '0;
				nxt.chunk_tag     = '0;
				nxt.chunk_length  = '0;
			end
			default: begin
			end
		endcase

		if (status != ST_SAMPLE) begin
			nxt.phase = PH_WAIT;
		end else if (word_in.end_of_file && nxt.phase != PH_WAIT) begin
			if (nxt.phase == PH_RIFF) begin
				status = ST_BAD_HEADER;
			end else if (nxt.phase == PH_FMT || nxt.phase == PH_DATA || nxt.phase == PH_SKIP) begin
				status = ST_OVERRUN;
			end else if (nxt.seen_flags[SEEN_DATA_BIT]) begin
				status = ST_DONE;
			end else begin
				status = ST_MISSING;
			end
		end

		res.sample_value  = $signed(sval);
		res.sample_valid  = have;
		res.channel_index = ch;
		res.status        = status;
		if (status == ST_DONE) begin
			res.sample_rate   = nxt.rate_held;
			res.channel_count = nxt.channels_held[1:0];
		end
		res_valid = have || (status != ST_SAMPLE);

		// every end of file re-arms for the next file
		if (word_in.end_of_file) begin
			nxt = STATE_INIT;
		end
	end

endmodule
`default_nettype wire

// File: rtl/wav_pcm_stream_parser.sv
`default_nettype none
// a result word is registered and appears in the cycle after the byte word that causes it
// throughput: one byte word per cycle unless stalled, set by the one state register
// a result register decouples the sides; bytes stall only while it is full and held
// reset: arst_n low clears the parse state and empties the result register
// every end_of_file byte returns the parser to its reset state
module wav_pcm_stream_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_valid,
	output logic                 byte_ready,
	input  wire wpsp_pkg::in_word_t  byte_word,
	output logic                 result_valid,
	input  wire                  result_ready,
	output wpsp_pkg::out_word_t  result_word
);
	import wpsp_pkg::*;

	// parse state, updated once for every accepted byte word
	parse_state_t state_q;
	parse_state_t state_d;

	// result produced by the current byte
	out_word_t step_res;
	logic      step_res_valid;

	// output register
	out_word_t result_word_q;
	logic      result_valid_q;

	logic take;

	// all per-byte work: header match, chunk walk, fmt capture, sample build
	wpsp_step u_step (
		.cur       (state_q),
		.word_in   (byte_word),
		.nxt       (state_d),
		.res       (step_res),
		.res_valid (step_res_valid)
	);

	// a new byte goes in whenever the result slot is empty or drains this cycle
	assign byte_ready = !result_valid_q || result_ready;
	assign take       = byte_valid && byte_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_INIT;
		end else if (take) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			// bytes that make no result leave the slot empty
			result_valid_q <= step_res_valid;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (take && step_res_valid) begin
			result_word_q <= step_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result_word  = result_word_q;

`ifndef ASSERT_OFF
	// an end of file byte always re-arms the header match
	a_eof_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		take && byte_word.end_of_file |=> state_q.phase == PH_RIFF && state_q.byte_in_field == '0)
		else $error("parser not re-armed after end of file");

	// a result word always carries a sample or a status
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_word.sample_valid || result_word.status != ST_SAMPLE)
		else $error("empty result word");

	// rate and channel count only go out with the done status
	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_word.status != ST_DONE |->
			result_word.sample_rate == '0 && result_word.channel_count == '0)
		else $error("format fields without done status");

	// no sample means zero sample and channel fields
	a_no_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_word.sample_valid |->
			result_word.sample_value == '0 && !result_word.channel_index)
		else $error("stale sample fields");

	// data phase is entered only after the data chunk has been opened
	a_data_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DATA |-> state_q.seen_flags[SEEN_DATA_BIT] &&
			state_q.seen_flags[SEEN_FMT_BIT])
		else $error("data phase without opened data chunk");
`endif

endmodule
`default_nettype wire

// File: tb/tb_wav_pcm_stream_parser.sv
`timescale 1ns / 100ps

module tb_wav_pcm_stream_parser;
	import wpsp_pkg::*;

	localparam int CLK_PERIOD    = 8;
	localparam int RESET_CYCLES  = 5;
	// the result is registered, so a short settle covers anything still in flight
	localparam int SETTLE_CYCLES = 16;
	localparam int TIMEOUT_NS    = 5_000_000;

	// shapes of generated files, clean ones first, then one per way a file can go wrong
	typedef enum int {
		FK_PLAIN,
		FK_EXTRA_CHUNKS,
		FK_BAD_MAGIC,
		FK_SHORT_HEADER,
		FK_CUT_BODY,
		FK_SHORT_FMT,
		FK_NO_DATA,
		FK_NOT_PCM,
		FK_BAD_CHANS,
		FK_BAD_BITS,
		FK_ODD_16,
		FK_DATA_FIRST,
		FK_CUT_TAIL,
		FK_NOISE,
		FK_COUNT
	} file_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	in_word_t byte_word = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_word_t result_word;

	// decoded words still owed by the block, oldest first
	out_word_t decoded_q[$];
	// parser state as the byte stream has left it
	parse_state_t dec = STATE_INIT;
	logic [7:0] file_bytes[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int fail_count = 0;
	int byte_count = 0;
	int file_count = 0;
	int sample_count = 0;
	int done_count = 0;
	int err_count = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	wav_pcm_stream_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_word    (byte_word),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_word  (result_word)
	);

	// ---------------------------------------------------------------
	// parser prediction
	// ---------------------------------------------------------------

	// back to the start of a chunk header
	function automatic void start_header();
		dec.phase = PH_HDR;
		dec.byte_in_field = '0;
		dec.chunk_tag = '0;
		dec.chunk_length = '0;
	endfunction

	// chunk header complete: pick the body phase, or report why the chunk is refused
	function automatic logic [3:0] enter_chunk();
		if (dec.chunk_tag == TAG_FMT) begin
			if (dec.chunk_length < FMT_MIN_LEN)
				return ST_SHORT_FMT;
			// a fmt chunk after data started is only length checked
			if (dec.seen_flags[SEEN_DATA_BIT]) begin
				dec.phase = PH_SKIP;
			end else begin
				dec.format_code = '0;
				dec.channels_held = '0;
				dec.rate_held = '0;
				dec.bits_held = '0;
				dec.seen_flags[SEEN_FMT_BIT] = 1'b1;
				dec.phase = PH_FMT;
			end
		end else if (dec.chunk_tag == TAG_DATA && !dec.seen_flags[SEEN_DATA_BIT]) begin
			// format checks wait until the first data chunk opens
			if (!dec.seen_flags[SEEN_FMT_BIT])
				return ST_DATA_NO_FMT;
			if (dec.format_code != FORMAT_PCM)
				return ST_NOT_PCM;
			if (dec.channels_held != 16'd1 && dec.channels_held != 16'd2)
				return ST_BAD_CHANS;
			if (dec.bits_held != 16'd8 && dec.bits_held != 16'd16)
				return ST_BAD_BITS;
			if (dec.bits_held == 16'd16 && dec.chunk_length[0])
				return ST_ODD_DATA;
			dec.seen_flags[SEEN_DATA_BIT] = 1'b1;
			dec.channel_toggle = 1'b0;
			dec.phase = PH_DATA;
		end else begin
			// unknown chunks and any later data chunk
			dec.phase = PH_SKIP;
		end
		if (dec.chunk_length == '0)
			start_header();
		return ST_SAMPLE;
	endfunction

	// one accepted byte: advance the state and queue the word it produces, if any
	function automatic void decode_byte(input logic [7:0] b, input logic eof);
		logic [31:0] off;
		logic [7:0] want;
		logic [3:0] st;
		logic have;
		out_word_t w;
		off = dec.byte_in_field;
		st = ST_SAMPLE;
		have = 1'b0;
		w = '0;
		case (dec.phase)
		PH_RIFF: begin
			// size bytes 4..7 match anything
			want = b;
			if (off < 4)
				want = 8'(TAG_RIFF >> (8 * off));
			else if (off >= 8 && off < 12)
				want = 8'(TAG_WAVE >> (8 * (off - 8)));
			if (b != want || off >= 12) begin
				st = ST_BAD_HEADER;
			end else begin
				dec.byte_in_field = off + 1;
				if (off == 11)
					start_header();
			end
		end
		PH_HDR: begin
			if (off < 4)
				dec.chunk_tag |= 32'(b) << (8 * off);
			else
				dec.chunk_length |= 32'(b) << (8 * ((off - 4) & 3));
			dec.byte_in_field = off + 1;
			if (off >= 7) begin
				dec.byte_in_field = '0;
				st = enter_chunk();
			end
		end
		PH_FMT, PH_DATA, PH_SKIP: begin
			if (dec.phase == PH_FMT) begin
				if (off < 2)
					dec.format_code |= 16'(b) << (8 * off);
				else if (off < 4)
					dec.channels_held |= 16'(b) << (8 * (off - 2));
				else if (off < 8)
					dec.rate_held |= 32'(b) << (8 * (off - 4));
				else if (off == 14 || off == 15)
					dec.bits_held |= 16'(b) << (8 * (off - 14));
			end else if (dec.phase == PH_DATA) begin
				if (dec.bits_held == 16'd8) begin
					// unsigned 8-bit recentred and moved to the top byte
					w.sample_value = {b ^ PCM_CENTER, 8'h00};
					have = 1'b1;
				end else if (!off[0]) begin
					dec.low_byte_hold = b;
				end else begin
					w.sample_value = {b, dec.low_byte_hold};
					have = 1'b1;
				end
				if (have) begin
					w.channel_index = dec.channel_toggle;
					if (dec.channels_held == 16'd2)
						dec.channel_toggle ^= 1'b1;
				end
			end
			dec.byte_in_field = off + 1;
			if (dec.byte_in_field == dec.chunk_length) begin
				if (dec.chunk_length[0]) begin
					dec.phase = PH_PAD;
					dec.byte_in_field = '0;
				end else begin
					start_header();
				end
			end
		end
		PH_PAD: start_header();
		default: ;
		endcase

		if (st != ST_SAMPLE) begin
			// error reported, swallow the rest of the file
			dec.phase = PH_WAIT;
		end else if (eof && dec.phase != PH_WAIT) begin
			if (dec.phase == PH_RIFF)
				st = ST_BAD_HEADER;
			else if (dec.phase == PH_FMT || dec.phase == PH_DATA || dec.phase == PH_SKIP)
				st = ST_OVERRUN;
			else if (dec.seen_flags[SEEN_DATA_BIT])
				st = ST_DONE;
			else
				st = ST_MISSING;
			if (st == ST_DONE) begin
				w.sample_rate = dec.rate_held;
				w.channel_count = dec.channels_held[1:0];
			end
		end
		// every end of file re-arms for the next one
		if (eof)
			dec = STATE_INIT;
		if (have || st != ST_SAMPLE) begin
			w.sample_valid = have;
			w.status = st;
			decoded_q.insert(decoded_q.size(), w);
		end
	endfunction

	// ---------------------------------------------------------------
	// byte side
	// ---------------------------------------------------------------

	// entered and left at a rising edge; valid stays up for a follow-on byte
	task automatic send_byte(input logic [7:0] b, input logic eof);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= '{byte_value: b, end_of_file: eof};
		// ready is stable by the falling edge, so the next rising edge takes the word
		do
			@(negedge clk);
		while (!byte_ready);
		@(posedge clk);
		decode_byte(b, eof);
		byte_count++;
	endtask

	// sender holds off until every owed word has come back
	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// result side
	// ---------------------------------------------------------------

	always @(posedge clk)
		result_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

	function automatic void check_field(input string name, input logic [31:0] exp,
			input logic [31:0] got);
		if (got !== exp) begin
			$error("%s expected %0h got %0h", name, exp, got);
			fail_count++;
		end
	endfunction

	// word taken at the coming rising edge; compared while the payload is steady
	always @(negedge clk) begin : result_check
		out_word_t want;
		if (arst_n && result_valid && result_ready) begin
			if (decoded_q.size() == 0) begin
				$error("result word with nothing owed: %p", result_word);
				fail_count++;
			end else begin
				want = decoded_q.pop_front();
				check_field("sample_value", 32'(want.sample_value),
					32'(result_word.sample_value));
				check_field("sample_valid", 32'(want.sample_valid), 32'(result_word.sample_valid));
				check_field("channel_index", 32'(want.channel_index),
					32'(result_word.channel_index));
				check_field("status", 32'(want.status), 32'(result_word.status));
				check_field("sample_rate", want.sample_rate, result_word.sample_rate);
				check_field("channel_count", 32'(want.channel_count),
					32'(result_word.channel_count));
			end
			if (result_word.sample_valid)
				sample_count++;
			if (result_word.status == ST_DONE)
				done_count++;
			else if (result_word.status != ST_SAMPLE)
				err_count++;
		end
	end

	// ---------------------------------------------------------------
	// file building
	// ---------------------------------------------------------------

	// one more byte at the end of the file image
	function automatic void put8(input logic [7:0] v);
		file_bytes.insert(file_bytes.size(), v);
	endfunction

	// little-endian, low byte first
	function automatic void put32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			put8(v[8 * i +: 8]);
	endfunction

	function automatic void put_riff();
		put32(TAG_RIFF);
		put32($urandom);
		put32(TAG_WAVE);
	endfunction

	function automatic void put_body(input int len);
		for (int i = 0; i < len; i++)
			put8(8'($urandom));
		// pad byte after an odd body
		if (len % 2 == 1)
			put8(8'($urandom));
	endfunction

	function automatic void add_fmt(input logic [15:0] code, input logic [15:0] chans,
			input logic [15:0] bits, input int len);
		logic [31:0] rate;
		logic [127:0] img;
		case ($urandom_range(3))
		0: rate = 32'd44100;
		1: rate = 32'd8000;
		2: rate = $urandom;
		default: rate = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
		endcase
		// byte rate and block align are never looked at
		img = {bits, 16'($urandom), 32'($urandom), rate, chans, code};
		put32(TAG_FMT);
		put32(len);
		for (int i = 0; i < len; i++)
			put8(i < 16 ? img[8 * i +: 8] : 8'($urandom));
		if (len % 2 == 1)
			put8(8'($urandom));
	endfunction

	function automatic void add_data(input int len);
		put32(TAG_DATA);
		put32(len);
		put_body(len);
	endfunction

	function automatic void add_other(input int len);
		put32($urandom);
		put32(len);
		put_body(len);
	endfunction

	function automatic void cut_to(input int len);
		while (file_bytes.size() > len)
			void'(file_bytes.pop_back());
	endfunction

	// every shape once first, then mostly clean files with random content
	function automatic file_kind_t next_kind();
		if (file_count < FK_COUNT)
			return file_kind_t'(file_count);
		if ($urandom_range(99) < 45)
			return $urandom_range(1) ? FK_PLAIN : FK_EXTRA_CHUNKS;
		return file_kind_t'($urandom_range(FK_COUNT - 1));
	endfunction

	function automatic void build_file(input file_kind_t kind);
		logic [15:0] code;
		logic [15:0] chans;
		logic [15:0] bits;
		int dlen;
		file_bytes.delete();
		code = FORMAT_PCM;
		chans = 16'($urandom_range(1, 2));
		bits = $urandom_range(1) ? 16'd8 : 16'd16;
		dlen = (bits == 16'd16) ? 2 * $urandom_range(0, 12) : $urandom_range(0, 23);
		case (kind)
		FK_NOT_PCM:   code = $urandom_range(1) ? 16'd0 : (16'($urandom) | 16'h2);
		FK_BAD_CHANS: chans = $urandom_range(1) ? 16'd0 : 16'($urandom_range(3, 65535));
		FK_BAD_BITS: begin
			do
				bits = 16'($urandom_range(0, 40));
			while (bits == 16'd8 || bits == 16'd16);
		end
		FK_ODD_16: begin
			bits = 16'd16;
			dlen = 2 * $urandom_range(0, 8) + 1;
		end
		FK_CUT_TAIL: begin
			// 8-bit odd body so the pad byte can go missing
			bits = 16'd8;
			dlen = 2 * $urandom_range(0, 10) + 1;
		end
		default: ;
		endcase

		case (kind)
		FK_NOISE: begin
			for (int i = $urandom_range(1, 24); i > 0; i--)
				put8(8'($urandom));
			if ($urandom_range(1))
				file_bytes[0] = TAG_RIFF[7:0];
		end
		FK_SHORT_HEADER: begin
			put_riff();
			cut_to($urandom_range(1, 11));
		end
		FK_SHORT_FMT: begin
			put_riff();
			add_fmt(code, chans, bits, $urandom_range(0, 15));
			add_data(dlen);
		end
		FK_NO_DATA: begin
			put_riff();
			if ($urandom_range(3) != 0)
				add_fmt(code, chans, bits, 16 + $urandom_range(0, 3));
			if ($urandom_range(1))
				add_other($urandom_range(0, 9));
		end
		FK_DATA_FIRST: begin
			put_riff();
			add_data(dlen);
			add_fmt(code, chans, bits, 16);
		end
		FK_EXTRA_CHUNKS: begin
			put_riff();
			if ($urandom_range(1))
				add_other($urandom_range(0, 9));
			// first fmt is junk and gets overwritten by the second
			add_fmt(16'($urandom), 16'($urandom), 16'($urandom), 16 + $urandom_range(0, 3));
			add_fmt(code, chans, bits, 16 + $urandom_range(0, 3));
			add_other(2 * $urandom_range(0, 4) + 1);
			add_data(dlen);
			// a later data chunk is skipped, a later fmt only length checked
			add_data($urandom_range(0, 9));
			add_fmt(16'($urandom), 16'($urandom), 16'($urandom),
				$urandom_range(3) == 0 ? $urandom_range(0, 15) : 16 + $urandom_range(0, 3));
			if ($urandom_range(1))
				add_other($urandom_range(0, 5));
		end
		default: begin
			put_riff();
			add_fmt(code, chans, bits, $urandom_range(3) == 0 ? 16 + $urandom_range(1, 5) : 16);
			add_data(dlen);
		end
		endcase

		case (kind)
		FK_BAD_MAGIC: begin
			// damage one byte of the RIFF or WAVE tag
			if ($urandom_range(1))
				file_bytes[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
			else
				file_bytes[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
		end
		FK_CUT_BODY: cut_to($urandom_range(13, file_bytes.size() - 1));
		FK_CUT_TAIL: begin
			// either drop the final pad or leave a partial chunk header
			if ($urandom_range(1)) begin
				void'(file_bytes.pop_back());
			end else begin
				for (int i = $urandom_range(1, 7); i > 0; i--)
					put8(8'($urandom));
			end
		end
		default: ;
		endcase
	endfunction

	task automatic send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_byte(file_bytes[i], i == file_bytes.size() - 1);
		file_count++;
	endtask

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// wrong fourth tag byte, then the rest of the file is swallowed
	task automatic test_bad_header();
		send_byte(8'h52, 1'b0);
		send_byte(8'h49, 1'b0);
		send_byte(8'h46, 1'b0);
		send_byte(8'h58, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	// file that stops inside the 12-byte header
	task automatic test_cut_header();
		send_byte(8'h52, 1'b0);
		send_byte(8'h49, 1'b1);
	endtask

	// all-zero and all-one bytes, with and without end of file
	task automatic test_byte_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b1);
	endtask

	// valid header with no chunks at all ends as missing chunk
	task automatic test_empty_wave();
		put32(TAG_RIFF);
		put32(32'hFFFF_FFFF);
		put32(TAG_WAVE);
		send_file();
		file_bytes.delete();
	endtask

	// generated files under one idling mix until the byte budget is spent
	task automatic test_files(input int send_pct, input int stall, input int budget);
		int start;
		wait_drained();
		send_idle_pct = send_pct;
		stall_pct = stall;
		start = byte_count;
		while (byte_count - start < budget) begin
			build_file(next_kind());
			send_file();
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bad_header();
		test_cut_header();
		test_byte_extremes();
		test_empty_wave();
		test_files(0, 0, 280);
		test_files(56, 0, 270);
		test_files(0, 56, 270);
		test_files(14, 14, 270);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (decoded_q.size() != 0) begin
			$error("%0d result words never arrived", decoded_q.size());
			fail_count++;
		end

		$display("streamed %0d bytes in %0d files, clean and broken, under four idling mixes",
			byte_count, file_count);
		$display("checked %0d samples, %0d clean ends and %0d error reports",
			sample_count, done_count, err_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// hang guard
	initial begin
		#TIMEOUT_NS;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
